// ===== design/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Request and result beats, operation codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int NUM_W = 16;   // operand numerator width
	localparam int DEN_W = 15;   // operand denominator width
	localparam int RNUM_W = 32;  // result numerator width
	localparam int RDEN_W = 31;  // result denominator width
	localparam int MOP_W = 17;   // signed multiplier operand width
	localparam int PROD_W = 2 * MOP_W;
	localparam int KCNT_W = 5;   // common power-of-two count
	localparam int DCNT_W = 5;   // divider step count

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]              req_type;
		logic signed [NUM_W-1:0] a_num;
		logic [DEN_W-1:0]        a_den;
		logic signed [NUM_W-1:0] b_num;
		logic [DEN_W-1:0]        b_den;
	} rau_req_t;

	typedef struct packed {
		logic signed [RNUM_W-1:0] res_num;
		logic [RDEN_W-1:0]        res_den;
		logic                     div_zero;
		logic                     is_greater;
		logic                     is_less;
		logic                     is_equal;
	} rau_res_t;

	typedef enum logic [1:0] {
		MUL_LHS,
		MUL_RHS,
		MUL_DEN,
		MUL_NUM
	} rau_mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LHS,
		ST_MUL_RHS,
		ST_MUL_DEN,
		ST_MUL_NUM,
		ST_FORM,
		ST_GCD,
		ST_DIV,
		ST_DONE
	} rau_state_t;

	typedef struct packed {
		logic         load;
		logic         mul_en;
		rau_mul_sel_t mul_sel;
		logic         form;
		logic         gcd_step;
		logic         div_init;
		logic         div_step;
	} rau_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic div_last;
	} rau_sts_t;

endpackage

// ===== design/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath: operand registers, shared multiplier, binary GCD, divider
// One 17x17 signed multiplier forms the cross products in turn; a binary
// GCD loop finds the common factor; two restoring dividers scale it out.
// ----------------------------------------------------------------------------
module rau_datapath import rau_pkg::*; (
	input  logic     clk,
	input  rau_req_t req,
	input  rau_cmd_t cmd,
	output rau_sts_t sts,
	output rau_res_t result
);

	// captured operands (zero denominator taken as 1)
	logic [1:0]              op_q;
	logic signed [NUM_W-1:0] an_q, bn_q;
	logic [DEN_W-1:0]        ad_q, bd_q;

	// products
	logic signed [RNUM_W-1:0] lhs_q, rhs_q, den_q, nm_q;

	// form results
	logic                neg_q, dz_q, gt_q, lt_q, eq_q;
	logic [RNUM_W-1:0]   mag_q;
	logic [RNUM_W-1:0]   dmag_q;

	// gcd loop
	logic [RNUM_W-1:0]   u_q, v_q;
	logic [KCNT_W-1:0]   k_q;

	// divider
	logic [RNUM_W-1:0]   g_q;
	logic [RNUM_W-1:0]   rem_a_q, rem_b_q, quo_a_q, quo_b_q;
	logic [DCNT_W-1:0]   cnt_q;

	// ---------------- multiplier ----------------
	logic signed [MOP_W-1:0]  mop_a, mop_b;
	logic signed [PROD_W-1:0] prod;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_LHS: begin
				mop_a = {an_q[NUM_W-1], an_q};
				mop_b = $signed({2'b00, bd_q});
			end
			MUL_RHS: begin
				mop_a = {bn_q[NUM_W-1], bn_q};
				mop_b = $signed({2'b00, ad_q});
			end
			MUL_DEN: begin
				mop_a = $signed({2'b00, ad_q});
				mop_b = (op_q == OP_DIV) ? {bn_q[NUM_W-1], bn_q} : $signed({2'b00, bd_q});
			end
			MUL_NUM: begin
				mop_a = {an_q[NUM_W-1], an_q};
				mop_b = {bn_q[NUM_W-1], bn_q};
			end
			default: begin
				mop_a = '0;
				mop_b = '0;
			end
		endcase
		prod = mop_a * mop_b;
	end

	// ---------------- form numerator / denominator ----------------
	logic signed [RNUM_W:0]   n_c, n_fix, n_abs;
	logic signed [RNUM_W-1:0] d_c, d_fix;
	logic                     bz;

	always_comb begin
		bz = (bn_q == '0);
		d_c = den_q;
		unique case (op_q)
			OP_ADD: n_c = $signed({lhs_q[RNUM_W-1], lhs_q}) + $signed({rhs_q[RNUM_W-1], rhs_q});
			OP_SUB: n_c = $signed({lhs_q[RNUM_W-1], lhs_q}) - $signed({rhs_q[RNUM_W-1], rhs_q});
			OP_MUL: n_c = $signed({nm_q[RNUM_W-1], nm_q});
			OP_DIV: begin
				n_c = bz ? '0 : $signed({lhs_q[RNUM_W-1], lhs_q});
				if (bz)
					d_c = RNUM_W'(1);
			end
			default: n_c = '0;
		endcase
		if (d_c == '0)
			d_c = RNUM_W'(1);
		if (d_c[RNUM_W-1]) begin
			n_fix = -n_c;
			d_fix = -d_c;
		end else begin
			n_fix = n_c;
			d_fix = d_c;
		end
		n_abs = n_fix[RNUM_W] ? -n_fix : n_fix;
	end

	// ---------------- gcd step ----------------
	logic [RNUM_W-1:0] diff_uv, diff_vu;
	assign diff_uv = u_q - v_q;
	assign diff_vu = v_q - u_q;

	// ---------------- divider step ----------------
	logic [RNUM_W:0]   ta, tb;
	logic              ba, bb;
	assign ta = {rem_a_q, quo_a_q[RNUM_W-1]};
	assign tb = {rem_b_q, quo_b_q[RNUM_W-1]};
	assign ba = (ta >= {1'b0, g_q});
	assign bb = (tb >= {1'b0, g_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.req_type;
			an_q <= req.a_num;
			bn_q <= req.b_num;
			ad_q <= (req.a_den == '0) ? DEN_W'(1) : req.a_den;
			bd_q <= (req.b_den == '0) ? DEN_W'(1) : req.b_den;
		end
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MUL_LHS: lhs_q <= prod[RNUM_W-1:0];
				MUL_RHS: rhs_q <= prod[RNUM_W-1:0];
				MUL_DEN: den_q <= prod[RNUM_W-1:0];
				MUL_NUM: nm_q  <= prod[RNUM_W-1:0];
				default: ;
			endcase
		end
		if (cmd.form) begin
			neg_q  <= n_fix[RNUM_W];
			mag_q  <= n_abs[RNUM_W-1:0];
			dmag_q <= d_fix;
			u_q    <= n_abs[RNUM_W-1:0];
			v_q    <= d_fix;
			k_q    <= '0;
			dz_q   <= (op_q == OP_DIV) && bz;
			gt_q   <= (lhs_q > rhs_q);
			lt_q   <= (lhs_q < rhs_q);
			eq_q   <= (an_q == bn_q) && (ad_q == bd_q);
		end
		if (cmd.gcd_step) begin
			priority if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + KCNT_W'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= diff_uv >> 1;
			end else begin
				v_q <= diff_vu >> 1;
			end
		end
		if (cmd.div_init) begin
			g_q     <= v_q << k_q;
			rem_a_q <= '0;
			rem_b_q <= '0;
			quo_a_q <= mag_q;
			quo_b_q <= dmag_q;
			cnt_q   <= '0;
		end
		if (cmd.div_step) begin
			rem_a_q <= ba ? RNUM_W'(ta - {1'b0, g_q}) : ta[RNUM_W-1:0];
			rem_b_q <= bb ? RNUM_W'(tb - {1'b0, g_q}) : tb[RNUM_W-1:0];
			quo_a_q <= {quo_a_q[RNUM_W-2:0], ba};
			quo_b_q <= {quo_b_q[RNUM_W-2:0], bb};
			cnt_q   <= cnt_q + DCNT_W'(1);
		end
	end

	assign sts.gcd_done = (u_q == '0);
	assign sts.div_last = (cnt_q == '1);

	assign result.res_num    = neg_q ? -$signed(quo_a_q) : $signed(quo_a_q);
	assign result.res_den    = quo_b_q[RDEN_W-1:0];
	assign result.div_zero   = dz_q;
	assign result.is_greater = gt_q;
	assign result.is_less    = lt_q;
	assign result.is_equal   = eq_q;

endmodule

// ===== design/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing state machine
// Steps the datapath through multiply, form, GCD and divide phases.
// ----------------------------------------------------------------------------
module rau_ctrl import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rau_sts_t sts,
	output rau_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	rau_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_sel = MUL_LHS;
		busy    = (state_q != ST_IDLE);
		done    = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_LHS;
				end
			end
			ST_MUL_LHS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LHS;
				state_d     = ST_MUL_RHS;
			end
			ST_MUL_RHS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RHS;
				state_d     = ST_MUL_DEN;
			end
			ST_MUL_DEN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DEN;
				state_d     = ST_MUL_NUM;
			end
			ST_MUL_NUM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_NUM;
				state_d     = ST_FORM;
			end
			ST_FORM: begin
				cmd.form = 1'b1;
				state_d  = ST_GCD;
			end
			ST_GCD: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply, divide of rationals
// Controller plus datapath; result reduced to lowest terms by binary GCD.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low. The unit then
// runs one request at a time: four products in turn on a single
// shared 17x17 multiplier, a form step for the signed numerator and
// positive denominator, the binary GCD loop (one shift or subtract per cycle,
// fewer steps for small values, then a step that sees it finish), and a
// pair of restoring dividers that divide numerator and denominator by the
// GCD. The result beat appears on result with done high for exactly one
// cycle; busy drops the cycle after. The receiver cannot hold the result
// off, so it must capture it in the done cycle. A zero operand denominator
// counts as 1.
// Divide with a zero second numerator returns 0/1 with div_zero set; the
// comparison flags are always valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  rau_req_t req,
	output logic     done,
	output rau_res_t result
);

	rau_cmd_t cmd;  // controller -> datapath
	rau_sts_t sts;  // datapath -> controller

	rau_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rau_datapath u_dp (
		.clk    (clk),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

	// an accepted beat always starts a run
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not start a run");

	// the unit frees itself right after the result beat
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("unit still busy after result beat");

	// at most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul_en, cmd.form, cmd.gcd_step, cmd.div_init,
			cmd.div_step}))
		else $error("overlapping datapath commands");

	// a reduced denominator is never zero
	a_den_nz: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.res_den != '0)
		else $error("zero result denominator");

	// divide by zero returns 0/1
	a_dz_val: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.div_zero |-> result.res_num == '0 && result.res_den == RDEN_W'(1))
		else $error("divide by zero result not 0/1");

endmodule

// ===== verif/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_checker: result predictor and scoreboard for the rational unit
// Watches request and result beats, predicts each reduced result with its
// flags, and compares in order. Reports a mismatch count to the bench top.
// ----------------------------------------------------------------------------
module rau_checker import rau_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  rau_req_t req,
	input  logic     done,
	input  rau_res_t result,
	output int       mismatches,
	output int       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	rau_res_t expected_results[$];
	int       errors;

	// Exact 64-bit arithmetic; operand ranges keep every product in range.
	function automatic rau_res_t rational_result(rau_req_t q);
		longint   an, ad, bn, bd, lhs, rhs, n, d, x, y, t;
		rau_res_t r;
		an = $signed(q.a_num);
		bn = $signed(q.b_num);
		ad = (q.a_den == '0) ? 64'sd1 : longint'(q.a_den);
		bd = (q.b_den == '0) ? 64'sd1 : longint'(q.b_den);
		lhs = an * bd;
		rhs = bn * ad;
		r = '0;
		case (q.req_type)
			OP_ADD: begin
				n = lhs + rhs;
				d = ad * bd;
			end
			OP_SUB: begin
				n = lhs - rhs;
				d = ad * bd;
			end
			OP_MUL: begin
				n = an * bn;
				d = ad * bd;
			end
			OP_DIV: begin
				if (bn == 0) begin
					r.div_zero = 1'b1;
					n = 0;
					d = 1;
				end else begin
					n = lhs;
					d = ad * bn;
				end
			end
		endcase
		if (d == 0)
			d = 1;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		// Euclid on magnitudes
		x = (n < 0) ? -n : n;
		y = d;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		if (x == 0)
			x = 1;
		n = n / x;
		d = d / x;
		r.res_num = n[31:0];
		r.res_den = d[30:0];
		r.is_greater = lhs > rhs;
		r.is_less = lhs < rhs;
		r.is_equal = (an == bn) && (ad == bd);
		return r;
	endfunction

	function automatic int field_differs(string name, longint want, longint got);
		if (want == got)
			return 0;
		$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rau_res_t want;
		int       bad;
		if (!arst_n) begin
			expected_results.delete();
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// result beat first: a new request can't share its edge anyway
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with none expected, got %0d/%0d",
						$time, $signed(result.res_num), result.res_den);
					errors++;
				end else begin
					want = expected_results.pop_front();
					bad = field_differs("res_num", $signed(want.res_num),
						$signed(result.res_num));
					bad += field_differs("res_den", want.res_den, result.res_den);
					bad += field_differs("div_zero", want.div_zero, result.div_zero);
					bad += field_differs("is_greater", want.is_greater, result.is_greater);
					bad += field_differs("is_less", want.is_less, result.is_less);
					bad += field_differs("is_equal", want.is_equal, result.is_equal);
					if (bad != 0)
						errors++;
				end
			end
			if (start && !busy)
				expected_results.push_back(rational_result(req));
			mismatches <= errors;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== verif/rational_arithmetic_unit_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: bench top for the rational arithmetic unit
// Directed corner beats, then random beats with bursty sender gaps; the
// checker beside the unit predicts and scores every result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	localparam int RANDOM_BEATS = 1600;
	localparam int CALM_TAIL = 200;     // final beats sent without gaps
	localparam int DRAIN_CYCLES = 120;  // longer than the worst-case request run
	localparam int STALL_LIMIT = 2000;  // cycles with no beat at all

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	rau_req_t req;
	rau_res_t result;
	int       mismatch_count;
	int       outstanding;
	int       stall_cycles;

	always #4ns clk = ~clk;

	rational_arithmetic_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	rau_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.result      (result),
		.mismatches  (mismatch_count),
		.outstanding (outstanding)
	);

	function automatic rau_req_t make_req(logic [1:0] op, int an, int ad, int bn, int bd);
		rau_req_t q;
		q.req_type = op;
		q.a_num = an[NUM_W-1:0];
		q.a_den = ad[DEN_W-1:0];
		q.b_num = bn[NUM_W-1:0];
		q.b_den = bd[DEN_W-1:0];
		return q;
	endfunction

	// Numerators: corner values, small values (lots of reduction), or anything.
	function automatic logic [NUM_W-1:0] pick_num();
		int corner[5] = '{-32768, -1, 0, 1, 32767};
		int v;
		case ($urandom_range(0, 7))
			0:       v = corner[$urandom_range(0, 4)];
			1, 2:    v = int'($urandom_range(0, 40)) - 20;
			default: v = $urandom;
		endcase
		return v[NUM_W-1:0];
	endfunction

	// Denominators: zero (taken as one), the extremes, small, or anything.
	function automatic logic [DEN_W-1:0] pick_den();
		int v;
		case ($urandom_range(0, 7))
			0:       v = 0;
			1:       v = 32767;
			2:       v = 1;
			3, 4:    v = $urandom_range(1, 24);
			default: v = $urandom_range(0, 32767);
		endcase
		return v[DEN_W-1:0];
	endfunction

	function automatic rau_req_t random_req();
		rau_req_t q;
		q.req_type = 2'($urandom_range(0, 3));
		q.a_num = pick_num();
		q.a_den = pick_den();
		q.b_num = pick_num();
		q.b_den = pick_den();
		// identical operands now and then: equality flag, zero differences
		if ($urandom_range(0, 9) == 0) begin
			q.b_num = q.a_num;
			q.b_den = q.a_den;
		end
		return q;
	endfunction

	// Present one request beat at the falling edge and hold it until the
	// rising edge that takes it (start high, busy low).
	task automatic send_beat(rau_req_t beat);
		@(negedge clk);
		start <= 1'b1;
		req <= beat;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start for a number of cycles; the request bus carries junk meanwhile.
	task automatic hold_off(int cycles);
		@(negedge clk);
		start <= 1'b0;
		req <= {$urandom, $urandom};
		repeat (cycles - 1) @(negedge clk);
	endtask

	// Watchdog: every cycle with neither a request nor a result beat counts.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else if (stall_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		bit gappy;
		start = 1'b0;
		req = '0;
		stall_cycles = 0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners, back to back.
		send_beat(make_req(OP_ADD, 1, 2, 1, 3));               // 5/6
		send_beat(make_req(OP_SUB, 1, 2, 1, 2));               // zero result, equal
		send_beat(make_req(OP_MUL, 32767, 1, 32767, 1));
		send_beat(make_req(OP_MUL, -32768, 1, -32768, 1));     // 2^30
		send_beat(make_req(OP_ADD, -32768, 32767, -32768, 32767));
		send_beat(make_req(OP_SUB, 32767, 1, -32768, 1));
		send_beat(make_req(OP_SUB, -32768, 1, 32767, 32767));
		send_beat(make_req(OP_DIV, 7, 3, 0, 5));               // divide by zero
		send_beat(make_req(OP_DIV, 0, 5, 0, 7));               // zero over zero
		send_beat(make_req(OP_DIV, 1, 3, -2, 5));              // sign moves up
		send_beat(make_req(OP_DIV, 1, 32767, -32768, 1));
		send_beat(make_req(OP_DIV, -32768, 32767, -32768, 32767));
		send_beat(make_req(OP_DIV, 32767, 1, 1, 32767));
		send_beat(make_req(OP_ADD, 3, 0, 1, 1));               // zero den as one
		send_beat(make_req(OP_SUB, 5, 0, 5, 1));               // equal through zero den
		send_beat(make_req(OP_MUL, -7, 0, 3, 0));
		send_beat(make_req(OP_ADD, 2, 4, 2, 4));               // unreduced operands
		send_beat(make_req(OP_DIV, 6, 8, 9, 12));
		send_beat(make_req(OP_ADD, 0, 0, 0, 0));
		send_beat(make_req(OP_SUB, 0, 0, 0, 0));
		send_beat(make_req(OP_MUL, 0, 0, 0, 0));
		send_beat(make_req(OP_DIV, 0, 0, 0, 0));
		send_beat(make_req(OP_MUL, -1, 32767, -1, 32767));
		send_beat(make_req(OP_ADD, 32767, 32766, 32766, 32767));

		// Random part. Each stretch of 64 beats is gapped or gap-free at random;
		// a gap starts either right after the take (unit busy) or once the
		// unit has gone idle, so the sender stalls on every phase.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i % 64 == 0)
				gappy = (i < RANDOM_BEATS - CALM_TAIL) && ($urandom_range(0, 2) != 0);
			send_beat(random_req());
			if (gappy && $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 1) == 1) begin
					do
						@(posedge clk);
					while (busy);
				end
				hold_off($urandom_range(1, 14));
			end
		end
		@(negedge clk);
		start <= 1'b0;

		// Drain, then give a stray result beat time to show up.
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
